FILE: hw/rtl/wfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Word frequency counter package
// Shared payload types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package wfc_pkg;

  localparam int unsigned APOSTROPHE = 39;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } wfc_in_t;

  typedef struct packed {
    logic [63:0] word_low;
    logic [63:0] word_high;
    logic [4:0]  word_length;
    logic [15:0] occurrences;
    logic        table_overflow;
    logic        last_entry;
  } wfc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_byte;    // Capture the input byte and append it to the word if it is a word character.
    logic clear_scan;   // Reset the scan index to the first entry.
    logic step_scan;    // Advance the scan index.
    logic bump_count;   // Increment the count of the scanned entry.
    logic insert_word;  // Store the current word as a new entry.
    logic set_overflow; // Record a dropped word.
    logic clear_word;   // Empty the current word.
    logic emit;         // Drive one result from the scanned entry.
    logic emit_empty;   // Drive the result for an empty table.
    logic clear_table;  // Empty the table and the overflow flag.
  } wfc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_word_char;
    logic word_empty;
    logic scan_done;  // The scan index has reached the fill count.
    logic matched;    // The entry read last cycle matches the current word.
    logic table_full;
    logic table_empty;
    logic last_scan;  // The scan index is at the last used entry.
  } wfc_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/wfc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Word frequency counter datapath
// Holds the current word, the word table in memory, counts and flags.
// ----------------------------------------------------------------------------
module wfc_datapath import wfc_pkg::*; #(
  parameter int MAX_WORD    = 16,
  parameter int TABLE_DEPTH = 64,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire wfc_in_t     in_word,
  input  wire wfc_cmd_t    cmd,
  output wfc_status_t      status,
  output wfc_out_t         result
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = $clog2(MAX_WORD + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [7:0]            cur_word [MAX_WORD];
  logic [LW-1:0]         cur_length;
  logic [7:0]            byte_reg;
  logic [MAX_WORD*8-1:0] tab_chars [TABLE_DEPTH];
  logic [LW-1:0]         tab_len   [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] tab_cnt   [TABLE_DEPTH];
  logic [MAX_WORD*8-1:0] rd_chars;
  logic [LW-1:0]         rd_len;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [IW-1:0]         rd_idx;
  logic [UW-1:0]         scan;
  logic [UW-1:0]         used;
  logic                  overflow;
  logic [MAX_WORD*8-1:0] cur_flat;
  logic                  is_upper;
  logic                  is_lower;
  logic [7:0]            folded;
  logic [127:0]          wide_chars;

  assign is_upper = (in_word.text_byte >= 8'd65) && (in_word.text_byte <= 8'd90);
  assign is_lower = (in_word.text_byte >= 8'd97) && (in_word.text_byte <= 8'd122);
  assign folded   = is_upper ? (in_word.text_byte + 8'd32) : in_word.text_byte;

  always_comb begin
    for (int k = 0; k < MAX_WORD; k++) begin
      cur_flat[k*8 +: 8] = (LW'(k) < cur_length) ? cur_word[k] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_length <= '0;
      used       <= '0;
      overflow   <= 1'b0;
      scan       <= '0;
    end else begin
      if (cmd.load_byte) begin
        byte_reg <= in_word.text_byte;
        if ((is_upper || is_lower || in_word.text_byte == 8'(APOSTROPHE))
            && cur_length < LW'(MAX_WORD)) begin
          cur_word[cur_length[$clog2(MAX_WORD > 1 ? MAX_WORD : 2)-1:0]] <= folded;
          cur_length <= cur_length + 1'b1;
        end
      end
      if (cmd.clear_scan) begin
        scan <= '0;
      end else if (cmd.step_scan) begin
        scan <= scan + 1'b1;
      end
      if (cmd.insert_word) begin
        used <= used + 1'b1;
      end
      if (cmd.set_overflow) begin
        overflow <= 1'b1;
      end
      if (cmd.clear_word) begin
        cur_length <= '0;
      end
      if (cmd.clear_table) begin
        used     <= '0;
        overflow <= 1'b0;
      end
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    rd_idx   <= scan[IW-1:0];
    rd_chars <= tab_chars[scan[IW-1:0]];
    rd_len   <= tab_len[scan[IW-1:0]];
    rd_cnt   <= tab_cnt[scan[IW-1:0]];
    if (cmd.insert_word) begin
      tab_chars[used[IW-1:0]] <= cur_flat;
      tab_len[used[IW-1:0]]   <= cur_length;
      tab_cnt[used[IW-1:0]]   <= COUNT_BITS'(1);
    end else if (cmd.bump_count && rd_cnt != CMAX) begin
      tab_cnt[rd_idx] <= rd_cnt + 1'b1;
    end
  end

  logic byte_word;
  assign byte_word = ((byte_reg >= 8'd65) && (byte_reg <= 8'd90)) ||
                     ((byte_reg >= 8'd97) && (byte_reg <= 8'd122)) ||
                     (byte_reg == 8'(APOSTROPHE));

  assign status.is_word_char = byte_word;
  assign status.word_empty   = (cur_length == '0);
  assign status.scan_done    = (scan >= used);
  assign status.matched      = (rd_len == cur_length) && (rd_chars == cur_flat);
  assign status.table_full   = (used == UW'(TABLE_DEPTH));
  assign status.table_empty  = (used == '0);
  assign status.last_scan    = (scan + 1'b1 == used);

  assign wide_chars = 128'(rd_chars);

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.emit_empty) begin
      result.word_low       <= cmd.emit ? wide_chars[63:0] : 64'd0;
      result.word_high      <= cmd.emit ? wide_chars[127:64] : 64'd0;
      result.word_length    <= cmd.emit ? 5'(rd_len) : 5'd0;
      result.occurrences    <= cmd.emit ? 16'(rd_cnt) : 16'd0;
      result.table_overflow <= overflow;
      result.last_entry     <= cmd.emit_empty || (scan + 1'b1 == used);
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/wfc_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Word frequency counter controller
// Sequences word end lookup, insertion and table emission.
// ----------------------------------------------------------------------------
module wfc_control import wfc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire wfc_in_t     in_word,
  input  wire wfc_status_t status,
  output wfc_cmd_t         cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASSIFY, S_SCAN, S_READ, S_CHECK, S_BUMP, S_FLUSH,
    S_EMIT_RD, S_EMIT, S_OUT
  } state_t;

  state_t state;
  logic   eot;
  logic   final_pass;

  always_comb begin
    cmd = '0;
    cmd.load_byte = (state == S_IDLE) && start;
    case (state)
      S_CLASSIFY: begin
        cmd.clear_scan = 1'b1;
      end
      S_SCAN: begin
        if (status.word_empty) begin
        end else if (status.scan_done) begin
          if (status.table_full) begin
            cmd.set_overflow = 1'b1;
          end else begin
            cmd.insert_word = 1'b1;
          end
          cmd.clear_word = 1'b1;
        end
      end
      S_CHECK: begin
        if (status.matched) begin
          cmd.bump_count = 1'b1;
          cmd.clear_word = 1'b1;
        end else begin
          cmd.step_scan = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd.clear_scan = 1'b1;
      end
      S_EMIT: begin
        if (status.table_empty) begin
          cmd.emit_empty = 1'b1;
        end else begin
          cmd.emit      = 1'b1;
          cmd.step_scan = 1'b1;
        end
      end
      S_OUT: begin
        cmd.clear_table = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      eot        <= 1'b0;
      final_pass <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            eot        <= in_word.end_of_text;
            final_pass <= 1'b0;
            state      <= S_CLASSIFY;
          end
        end
        S_CLASSIFY: begin
          state <= (status.is_word_char && !final_pass) ? S_FLUSH : S_SCAN;
        end
        S_SCAN: begin
          if (status.word_empty || status.scan_done) begin
            state <= S_FLUSH;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= status.matched ? S_BUMP : S_SCAN;
        end
        S_BUMP: begin
          state <= S_FLUSH;
        end
        S_FLUSH: begin
          if (!eot) begin
            state <= S_IDLE;
          end else if (!final_pass) begin
            final_pass <= 1'b1;
            state      <= S_CLASSIFY;
          end else begin
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          done  <= 1'b1;
          state <= (status.table_empty || status.last_scan) ? S_OUT : S_EMIT_RD;
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after start");
  a_one_cmd_insert: assert property (@(posedge clk) disable iff (rst)
    !(cmd.insert_word && cmd.set_overflow)) else $error("insert and overflow together");
  a_done_in_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EMIT)) else $error("result outside emission");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/word_frequency_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Word frequency counter
// Counts distinct words in a byte stream and emits the table at end of text.
// ----------------------------------------------------------------------------
// Channel   Signals                Handshake
// input     start, busy, in_word   taken when start is high and busy low
// result    done, result           done high for one cycle per result, no stall
//
// A byte that continues a word goes from classify straight to flush. A word end
// scans the stored entries until one matches and bumps its count, or else inserts
// the word. At end of text each stored entry is read and then emitted in turn.
// Reset is synchronous and leaves the table empty with no clearing pass.
// ----------------------------------------------------------------------------
module word_frequency_counter import wfc_pkg::*; #(
  parameter int MAX_WORD    = 16,
  parameter int TABLE_DEPTH = 64,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire wfc_in_t in_word,
  output logic         busy,
  output logic         done,
  output wfc_out_t     result
);

  wfc_cmd_t    cmd;
  wfc_status_t status;

  wfc_control u_control (
    .clk, .rst, .start, .in_word, .status, .cmd, .busy, .done
  );

  wfc_datapath #(
    .MAX_WORD(MAX_WORD), .TABLE_DEPTH(TABLE_DEPTH), .COUNT_BITS(COUNT_BITS)
  ) u_datapath (
    .clk, .rst, .in_word, .cmd, .status, .result
  );

endmodule
`default_nettype wire
